[rtl/poram_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the path ORAM access block.
// No dependencies; poram_cell, poram_stash and path_oram_access import this package.
package poram_pkg;

  // Default sizes of the tree, the buckets, the stash and the payload.
  localparam int unsigned TreeLevelsDef  = 6;
  localparam int unsigned BucketSlotsDef = 4;
  localparam int unsigned StashDepthDef  = 64;
  localparam int unsigned PayloadBitsDef = 64;

  // Stash positions travel at the widest supported stash depth (256).
  localparam int unsigned StashPosW = 8;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Request operation codes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    STASH_NOP    = 2'd0,
    STASH_APPEND = 2'd1,
    STASH_WRITE  = 2'd2,
    STASH_REMOVE = 2'd3
  } stash_cmd_e;

  // Command broadcast along the stash chain.
  typedef struct packed {
    stash_cmd_e           cmd;
    logic [StashPosW-1:0] pos;
  } stash_ctl_t;

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_MAP       = 11'b000_0000_0100,
    S_FETCH_RD  = 11'b000_0000_1000,
    S_FETCH_CHK = 11'b000_0001_0000,
    S_LOOKUP    = 11'b000_0010_0000,
    S_SERVE     = 11'b000_0100_0000,
    S_EV_RD     = 11'b000_1000_0000,
    S_EV_CHK    = 11'b001_0000_0000,
    S_EV_CLR    = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_e;

endpackage

[rtl/poram_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the path ORAM access block.
// No dependencies.
interface poram_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  block_address;
  logic [63:0] write_data;
  logic [5:0]  random_leaf;

  modport source (output valid, operation, block_address, write_data, random_leaf,
                  input ready);
  modport sink (input valid, operation, block_address, write_data, random_leaf,
                output ready);
endinterface

interface poram_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [1:0]  status;
  logic [6:0]  stash_occupancy;

  modport source (output valid, read_data, status, stash_occupancy, input ready);
  modport sink (input valid, read_data, status, stash_occupancy, output ready);
endinterface

[rtl/poram_cell.sv]
`timescale 1ns / 1ps
// One stash entry: block address and payload, loaded, updated or shifted
// from its right-hand neighbor. Depends on poram_pkg.
module poram_cell import poram_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = TreeLevelsDef,
  parameter int unsigned PW  = PayloadBitsDef
) (
  input  logic          clk_i,
  input  stash_ctl_t    ctl_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [PW-1:0] wr_payload_i,
  input  logic [AW-1:0] nb_addr_i,
  input  logic [PW-1:0] nb_payload_i,
  output logic [AW-1:0] addr_o,
  output logic [PW-1:0] payload_o
);

  localparam logic [StashPosW-1:0] MyPos = StashPosW'(IDX);

  logic [AW-1:0] addr_q;
  logic [PW-1:0] payload_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      STASH_APPEND: begin
        if (ctl_i.pos == MyPos) begin
          addr_q    <= wr_addr_i;
          payload_q <= wr_payload_i;
        end
      end
      STASH_WRITE: begin
        if (ctl_i.pos == MyPos) payload_q <= wr_payload_i;
      end
      STASH_REMOVE: begin
        // close the gap: every entry at or past the hole takes its neighbor
        if (MyPos >= ctl_i.pos) begin
          addr_q    <= nb_addr_i;
          payload_q <= nb_payload_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign addr_o    = addr_q;
  assign payload_o = payload_q;

endmodule

[rtl/poram_stash.sv]
`timescale 1ns / 1ps
// Stash as a row of poram_cell entries with one indexed read port.
// Depends on poram_pkg and poram_cell.
module poram_stash import poram_pkg::*; #(
  parameter int unsigned DEPTH = StashDepthDef,
  parameter int unsigned AW    = TreeLevelsDef,
  parameter int unsigned PW    = PayloadBitsDef,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  stash_ctl_t    ctl_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [PW-1:0] wr_payload_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic [AW-1:0] rd_addr_o,
  output logic [PW-1:0] rd_payload_o
);

  logic [AW-1:0] addr_a    [DEPTH];
  logic [PW-1:0] payload_a [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [AW-1:0] nb_addr;
    logic [PW-1:0] nb_payload;
    if (i == DEPTH - 1) begin : g_tail
      // last entry keeps its own value; it is past the fill after a removal
      assign nb_addr    = addr_a[i];
      assign nb_payload = payload_a[i];
    end else begin : g_mid
      assign nb_addr    = addr_a[i+1];
      assign nb_payload = payload_a[i+1];
    end
    poram_cell #(.IDX(i), .AW(AW), .PW(PW)) u_cell (
      .clk_i,
      .ctl_i,
      .wr_addr_i,
      .wr_payload_i,
      .nb_addr_i    (nb_addr),
      .nb_payload_i (nb_payload),
      .addr_o       (addr_a[i]),
      .payload_o    (payload_a[i])
    );
  end

  assign rd_addr_o    = addr_a[rd_idx_i];
  assign rd_payload_o = payload_a[rd_idx_i];

endmodule

[rtl/path_oram_access.sv]
`timescale 1ns / 1ps
// Path ORAM access engine: tree memories, position map, sequencer.
// Depends on poram_pkg, poram_if and poram_stash.
//
//  channel | dir | transfer when       | payload
//  --------+-----+---------------------+---------------------------------------------
//  req_i   | in  | valid && ready      | operation, block_address, write_data, random_leaf
//  rsp_o   | out | valid && ready      | read_data, status, stash_occupancy
//
// One access at a time. Each access steps through idle, map, a fetch of every path slot,
// a stash lookup and serve, then, level by level from leaf to root, a walk over the stash
// entries and a clear of the slots left unfilled, and finally done; the serial stash walk
// against the single position-map read port dominates the access time.
// Out-of-range requests go from idle straight to done.
// After reset a clearing pass empties every tree slot and zeroes the position
// map; no request is taken meanwhile.
// The response register holds a finished result while the sink stalls; the
// next request is taken once that result has been loaded.
module path_oram_access import poram_pkg::*; #(
  parameter int unsigned TREE_LEVELS  = TreeLevelsDef,
  parameter int unsigned BUCKET_SLOTS = BucketSlotsDef,
  parameter int unsigned STASH_DEPTH  = StashDepthDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  poram_req_if.sink    req_i,
  poram_rsp_if.source  rsp_o
);

  localparam int unsigned BlockCount = 1 << TREE_LEVELS;
  localparam int unsigned NodeCount  = (2 << TREE_LEVELS) - 1;
  localparam int unsigned SlotCount  = NodeCount * BUCKET_SLOTS;
  localparam int unsigned AW         = TREE_LEVELS;        // block address / leaf
  localparam int unsigned SlotW      = $clog2(SlotCount);
  localparam int unsigned FillW      = $clog2(STASH_DEPTH + 1);
  localparam int unsigned IdxW       = $clog2(STASH_DEPTH);
  localparam int unsigned LvlW       = $clog2(TREE_LEVELS + 1);
  localparam int unsigned SlotCntW   = $clog2(BUCKET_SLOTS + 1);

  localparam logic [FillW-1:0]    FillMax   = FillW'(STASH_DEPTH);
  localparam logic [SlotW-1:0]    ClrLast   = SlotW'(SlotCount - 1);
  localparam logic [LvlW-1:0]     LvlTop    = LvlW'(TREE_LEVELS);
  localparam logic [SlotCntW-1:0] SlotsFull = SlotCntW'(BUCKET_SLOTS);
  localparam logic [SlotCntW-1:0] SlotLast  = SlotCntW'(BUCKET_SLOTS - 1);

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;

  logic                    op_q;
  logic [AW-1:0]           addr_q;
  logic [PAYLOAD_BITS-1:0] wdata_q;
  logic [AW-1:0]           remap_leaf_q;
  logic [AW-1:0]           leaf_q;

  logic [LvlW-1:0]     level_q, level_d;
  logic [SlotCntW-1:0] slot_q, slot_d;     // fetch slot / eviction placed count
  logic [FillW-1:0]    scan_q, scan_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [SlotW-1:0]    clr_q;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;

  logic [PAYLOAD_BITS-1:0] rdata_q, rdata_d;
  logic [1:0]              status_q, status_d;

  logic                    out_valid_q;
  logic [63:0]             out_rdata_q;
  logic [1:0]              out_status_q;
  logic [6:0]              out_occ_q;

  // ---------------------------------------------------------------- memories
  logic [AW:0]             tag_mem [SlotCount];   // MSB = slot holds a block
  logic [PAYLOAD_BITS-1:0] pay_mem [SlotCount];
  logic [AW-1:0]           pm_mem  [BlockCount];

  logic [AW:0]             tag_rd_q;
  logic [PAYLOAD_BITS-1:0] pay_rd_q;
  logic [AW-1:0]           pm_rd_q;

  logic                    tree_we;
  logic [SlotW-1:0]        tree_widx;
  logic [AW:0]             tree_wtag;
  logic [PAYLOAD_BITS-1:0] tree_wpay;
  logic                    pm_we;
  logic [AW-1:0]           pm_widx, pm_wdata, pm_ridx;

  // ---------------------------------------------------------------- stash
  stash_ctl_t              st_ctl;
  logic [AW-1:0]           st_waddr;
  logic [PAYLOAD_BITS-1:0] st_wpay;
  logic [IdxW-1:0]         st_ridx;
  logic [AW-1:0]           st_raddr;
  logic [PAYLOAD_BITS-1:0] st_rpay;

  poram_stash #(.DEPTH(STASH_DEPTH), .AW(AW), .PW(PAYLOAD_BITS)) u_stash (
    .clk_i,
    .ctl_i        (st_ctl),
    .wr_addr_i    (st_waddr),
    .wr_payload_i (st_wpay),
    .rd_idx_i     (st_ridx),
    .rd_addr_o    (st_raddr),
    .rd_payload_o (st_rpay)
  );

  // ---------------------------------------------------------------- path geometry
  logic [LvlW-1:0]  shamt;
  logic [31:0]      node_idx;
  logic [SlotW-1:0] slot_idx;
  logic [AW-1:0]    hi_mask;
  logic             eligible;
  logic             in_range;
  logic             req_fire;
  logic             out_free;

  // node on the current path level: (2^level - 1) + (leaf >> (L - level))
  assign shamt    = LvlTop - level_q;
  assign node_idx = ((32'd1 << level_q) - 32'd1) + 32'(leaf_q >> shamt);
  assign slot_idx = SlotW'(node_idx * BUCKET_SLOTS + 32'(slot_q));
  // a stash block may sit at this level when its leaf agrees above the shift
  assign hi_mask  = {AW{1'b1}} << shamt;
  assign eligible = ((pm_rd_q ^ leaf_q) & hi_mask) == '0;

  assign in_range = 32'(req_i.block_address) < BlockCount;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    slot_d    = slot_q;
    scan_d    = scan_q;
    fill_d    = fill_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    rdata_d   = rdata_q;
    status_d  = status_q;

    st_ctl.cmd = STASH_NOP;
    st_ctl.pos = '0;
    st_waddr   = tag_rd_q[AW-1:0];
    st_wpay    = pay_rd_q;
    st_ridx    = scan_q[IdxW-1:0];

    tree_we   = 1'b0;
    tree_widx = slot_idx;
    tree_wtag = '0;
    tree_wpay = '0;

    pm_we    = 1'b0;
    pm_widx  = addr_q;
    pm_wdata = remap_leaf_q;
    pm_ridx  = AW'(req_i.block_address);

    case (state_q)
      S_CLEAR: begin
        // sweep every slot empty and every map entry to leaf 0
        tree_we   = 1'b1;
        tree_widx = clr_q;
        pm_we     = 32'(clr_q) < BlockCount;
        pm_widx   = AW'(clr_q);
        pm_wdata  = '0;
        if (clr_q == ClrLast) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          rdata_d  = '0;
          if (in_range) begin
            state_d = S_MAP;
          end else begin
            status_d = STATUS_RANGE;
            state_d  = S_DONE;
          end
        end
      end
      S_MAP: begin
        level_d = '0;
        slot_d  = '0;
        state_d = S_FETCH_RD;
      end
      S_FETCH_RD: begin
        state_d = S_FETCH_CHK;
      end
      S_FETCH_CHK: begin
        if (tag_rd_q[AW] && fill_q == FillMax) begin
          status_d = STATUS_OVERFLOW;
          state_d  = S_DONE;
        end else begin
          if (tag_rd_q[AW]) begin
            st_ctl.cmd = STASH_APPEND;
            st_ctl.pos = StashPosW'(fill_q);
            fill_d     = fill_q + 1'b1;
          end
          state_d = S_FETCH_RD;
          if (slot_q == SlotLast) begin
            slot_d = '0;
            if (level_q == LvlTop) begin
              scan_d  = '0;
              hit_d   = 1'b0;
              state_d = S_LOOKUP;
            end else begin
              level_d = level_q + 1'b1;
            end
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        // first match in stash order wins
        if (scan_q == fill_q) begin
          state_d = S_SERVE;
        end else if (st_raddr == addr_q) begin
          hit_d     = 1'b1;
          hit_idx_d = scan_q[IdxW-1:0];
          state_d   = S_SERVE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_SERVE: begin
        st_ridx  = hit_idx_q;
        st_waddr = addr_q;
        st_wpay  = wdata_q;
        level_d  = LvlTop;
        slot_d   = '0;
        scan_d   = '0;
        status_d = STATUS_OK;
        state_d  = S_EV_RD;
        if (op_q == OP_WRITE) begin
          if (hit_q) begin
            st_ctl.cmd = STASH_WRITE;
            st_ctl.pos = StashPosW'(hit_idx_q);
            pm_we      = 1'b1;
          end else if (fill_q == FillMax) begin
            status_d = STATUS_OVERFLOW;
            state_d  = S_DONE;
          end else begin
            st_ctl.cmd = STASH_APPEND;
            st_ctl.pos = StashPosW'(fill_q);
            fill_d     = fill_q + 1'b1;
            pm_we      = 1'b1;
          end
        end else begin
          pm_we = 1'b1;
          if (hit_q) rdata_d = st_rpay;
        end
      end
      S_EV_RD: begin
        pm_ridx = st_raddr;
        if (scan_q < fill_q && slot_q < SlotsFull) state_d = S_EV_CHK;
        else state_d = S_EV_CLR;
      end
      S_EV_CHK: begin
        if (eligible) begin
          tree_we    = 1'b1;
          tree_wtag  = {1'b1, st_raddr};
          tree_wpay  = st_rpay;
          slot_d     = slot_q + 1'b1;
          st_ctl.cmd = STASH_REMOVE;
          st_ctl.pos = StashPosW'(scan_q);
          fill_d     = fill_q - 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
        state_d = S_EV_RD;
      end
      S_EV_CLR: begin
        if (slot_q == SlotsFull) begin
          slot_d = '0;
          scan_d = '0;
          if (level_q == '0) begin
            state_d = S_DONE;
          end else begin
            level_d = level_q - 1'b1;
            state_d = S_EV_RD;
          end
        end else begin
          // drop the rest of the bucket: empty tag, zero payload
          tree_we = 1'b1;
          slot_d  = slot_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fill_q      <= '0;
      level_q     <= '0;
      slot_q      <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      fill_q  <= fill_d;
      level_q <= level_d;
      slot_q  <= slot_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload and operand registers
  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    rdata_q   <= rdata_d;
    status_q  <= status_d;
    if (req_fire) begin
      op_q         <= req_i.operation;
      addr_q       <= AW'(req_i.block_address);
      wdata_q      <= PAYLOAD_BITS'(req_i.write_data);
      remap_leaf_q <= AW'(req_i.random_leaf);
    end
    if (state_q == S_MAP) leaf_q <= pm_rd_q;
    if (state_q == S_DONE && out_free) begin
      out_rdata_q  <= 64'(rdata_q);
      out_status_q <= status_q;
      out_occ_q    <= 7'(fill_q);
    end
  end

  // tree and position-map memories, registered reads
  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tag_mem[tree_widx] <= tree_wtag;
      pay_mem[tree_widx] <= tree_wpay;
    end
    tag_rd_q <= tag_mem[slot_idx];
    pay_rd_q <= pay_mem[slot_idx];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_widx] <= pm_wdata;
    pm_rd_q <= pm_mem[pm_ridx];
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.read_data       = out_rdata_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.stash_occupancy = out_occ_q;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax) else $error("stash fill past depth");

  a_range_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && !in_range |=> state_q == S_DONE)
    else $error("out-of-range request did not finish at once");

  a_evict_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EV_CHK && eligible |=> fill_q == $past(fill_q) - 1'b1)
    else $error("eviction did not remove a stash entry");
`endif

endmodule
